@@ hw/rtl/pcxrle_pkg.sv @@
package pcxrle_pkg;

    // run limit and code bytes of the pcx scheme
    localparam logic [5:0] C_RUN_MAX   = 6'd63;
    localparam logic [7:0] C_CNT_BASE  = 8'hC0;
    localparam logic [7:0] C_ESC_LIMIT = 8'hBF;
    localparam logic [7:0] C_FULL_RUN  = 8'hFF;
    localparam logic [7:0] C_ESC       = 8'hC1;

    // bytes one item may cause
    localparam int unsigned MAX_BYTES = 4;
    localparam int unsigned QUEUE_DEPTH = 2;

    // a pair of bytes from one run flush
    typedef struct packed {
        logic [1:0][7:0] bytes;
        logic [1:0]      num;
    } t_pair;

    // byte group handed from front to back
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                num;
        logic                      line_done;
    } t_cmd;

    function automatic t_pair flush_run(input logic [7:0] colour, input logic [5:0] count);
        t_pair p;
        p = '0;
        if (count > 6'd1) begin
            p.bytes[0] = C_CNT_BASE | {2'b00, count};
            p.bytes[1] = colour;
            p.num      = 2'd2;
        end else if (count == 6'd1) begin
            if (colour > C_ESC_LIMIT) begin
                p.bytes[0] = C_ESC;
                p.bytes[1] = colour;
                p.num      = 2'd2;
            end else begin
                p.bytes[0] = colour;
                p.num      = 2'd1;
            end
        end
        return p;
    endfunction

endpackage

@@ hw/rtl/pcxrle_ifs.sv @@
interface pcxrle_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       end_of_line;

    modport source (output valid, output pixel, output end_of_line, input ready);
    modport sink (input valid, input pixel, input end_of_line, output ready);
endinterface

interface pcxrle_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       line_done;
    logic       last;

    modport source (output valid, output out_byte, output line_done, output last, input ready);
    modport sink (input valid, input out_byte, input line_done, input last, output ready);
endinterface

@@ hw/rtl/pcxrle_front.sv @@
module pcxrle_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pcxrle_pix_if.sink           i_pix,
    input  logic                 i_full,
    output logic                 o_push,
    output pcxrle_pkg::t_cmd     o_cmd
);

    logic [7:0] r_colour, n_colour;
    logic [5:0] r_count, n_count;
    logic       r_line_start, n_line_start;

    logic              take;
    logic [5:0]        cnt_inc;
    logic [5:0]        mid_count;
    pcxrle_pkg::t_pair first_p;
    pcxrle_pkg::t_pair second_p;
    pcxrle_pkg::t_cmd  cmd;
    logic [2:0]        idx;

    assign i_pix.ready = !i_full;
    assign take        = i_pix.valid && !i_full;
    assign cnt_inc     = r_count + 6'd1;

    always_comb begin
        first_p      = '0;
        second_p     = '0;
        n_colour     = r_colour;
        mid_count    = r_count;
        cmd          = '0;
        idx          = '0;
        // run update for the incoming pixel
        if (r_line_start) begin
            n_colour  = i_pix.pixel;
            mid_count = 6'd1;
        end else if (i_pix.pixel == r_colour) begin
            if (cnt_inc == pcxrle_pkg::C_RUN_MAX) begin
                first_p.bytes[0] = pcxrle_pkg::C_FULL_RUN;
                first_p.bytes[1] = r_colour;
                first_p.num      = 2'd2;
                mid_count        = 6'd0;
            end else begin
                mid_count = cnt_inc;
            end
        end else begin
            first_p   = pcxrle_pkg::flush_run(r_colour, r_count);
            n_colour  = i_pix.pixel;
            mid_count = 6'd1;
        end
        // end of line flushes whatever is pending
        if (i_pix.end_of_line) begin
            second_p     = pcxrle_pkg::flush_run(n_colour, mid_count);
            n_count      = 6'd0;
            n_line_start = 1'b1;
        end else begin
            n_count      = mid_count;
            n_line_start = 1'b0;
        end
        cmd.bytes[0] = first_p.bytes[0];
        cmd.bytes[1] = first_p.bytes[1];
        for (int j = 0; j < 2; j++) begin
            idx = {1'b0, first_p.num} + 3'(j);
            if (2'(j) < second_p.num) begin
                cmd.bytes[idx[1:0]] = second_p.bytes[j];
            end
        end
        cmd.num       = {1'b0, first_p.num} + {1'b0, second_p.num};
        cmd.line_done = i_pix.end_of_line;
    end

    assign o_push = take && (cmd.num != 3'd0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour     <= '0;
            r_count      <= '0;
            r_line_start <= 1'b1;
        end else if (take) begin
            r_colour     <= n_colour;
            r_count      <= n_count;
            r_line_start <= n_line_start;
        end
    end

endmodule

@@ hw/rtl/pcxrle_queue.sv @@
module pcxrle_queue #(
    parameter int unsigned DEPTH = pcxrle_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  pcxrle_pkg::t_cmd     i_cmd,
    output logic                 o_full,
    output logic                 o_head_valid,
    output pcxrle_pkg::t_cmd     o_head,
    input  logic                 i_pop
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    pcxrle_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_fill;

    logic do_pop;

    assign o_full       = (r_fill == CW'(DEPTH));
    assign o_head_valid = (r_fill != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !do_pop) begin
                r_fill <= r_fill + CW'(1);
            end else if (do_pop && !i_push) begin
                r_fill <= r_fill - CW'(1);
            end
        end
    end

endmodule

@@ hw/rtl/pcxrle_back.sv @@
module pcxrle_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  pcxrle_pkg::t_cmd     i_head,
    output logic                 o_pop,
    pcxrle_code_if.source        o_code
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_line_done;
    logic       r_last;

    logic load;
    logic is_last;

    assign load    = !r_valid || o_code.ready;
    assign is_last = ({1'b0, r_idx} + 3'd1) == i_head.num;
    assign o_pop   = load && i_head_valid && is_last;

    assign o_code.valid     = r_valid;
    assign o_code.out_byte  = r_byte;
    assign o_code.line_done = r_line_done;
    assign o_code.last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_head_valid;
            if (i_head_valid) begin
                r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            r_byte      <= i_head.bytes[r_idx];
            r_last      <= is_last;
            r_line_done <= is_last && i_head.line_done;
        end
    end

endmodule

@@ hw/rtl/pcx_scanline_rle_encoder_core.sv @@
// channel   | dir | handshake     | payload
// ----------+-----+---------------+------------------------------------
// i_pix     | in  | valid / ready | pixel[7:0], end_of_line
// o_code    | out | valid / ready | out_byte[7:0], line_done, last
//
// one pixel item is taken per cycle while the byte queue has room; each item
// gives zero to four bytes, and the output register sends one byte per cycle while
// o_code is ready.
// first byte of an item passes through the queue and then the output register before it shows
// synchronous active-low reset clears run state, queue and output valid
// a stalled output holds its byte; the input stalls only when the queue is full
module pcx_scanline_rle_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = pcxrle_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcxrle_pix_if.sink    i_pix,
    pcxrle_code_if.source o_code
);

    // front to queue
    logic             push;
    logic             full;
    pcxrle_pkg::t_cmd cmd;

    // queue to back
    logic             head_valid;
    pcxrle_pkg::t_cmd head;
    logic             pop;

    // front: keeps colour, run length and line start, turns each pixel into
    // a group of up to four code bytes; silent pixels push nothing
    pcxrle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    // short queue of byte groups so front and back stall on their own
    pcxrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (cmd),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // back: walks the head group one byte a cycle, while o_code is ready, into the
    // output register, marking the group's last byte and the end of the scanline
    pcxrle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_code       (o_code)
    );

endmodule
